/* rtl/core/flsa_pkg.sv */
package flsa_pkg;

  // Payload widths of the channels and of the configuration port.
  localparam int FUNC_W     = 2;
  localparam int SLOT_W     = 8;
  localparam int ADDR_W     = 32;
  localparam int USED_W     = 24;
  localparam int ALLOC_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int OBJ_W      = 16;
  localparam int POOL_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REBUILD = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_CAP,
    ST_SWEEP,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic div_step;
    logic cap;
    logic sweep_wr;
    logic rebuild_fin;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic sweep_done;
  } dpath_sts_t;

endpackage

/* rtl/core/flsa_if.sv */
interface flsa_req_if;
  import flsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SLOT_W-1:0]   free_slot;
  modport source (output valid, output func, output free_slot, input ready);
  modport sink   (input valid, input func, input free_slot, output ready);
endinterface

interface flsa_rsp_if;
  import flsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [ADDR_W-1:0]   address;
  logic [USED_W-1:0]   used_bytes;
  logic [ALLOC_W-1:0]  allocations;
  modport source (output valid, output status, output slot, output address,
                  output used_bytes, output allocations, input ready);
  modport sink   (input valid, input status, input slot, input address,
                  input used_bytes, input allocations, output ready);
endinterface

interface flsa_cfg_if;
  import flsa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/free_list_slot_allocator.sv */
// Allocate, free and no-op: the request is latched, and the execute state loads the result
// register once it is free. A new request is taken only after the previous one has executed.
// Rebuild: the 32-step divider finds the slot count n, which is capped at SLOTS, and the
// link sweep then writes one entry per cycle before the result register is loaded.
// Reset clears the controller, head (empty list), counters, base and pool size, and sets the
// object size to 1; the link RAM is not cleared and is reachable only after a rebuild links it.
module free_list_slot_allocator #(
  parameter int SLOTS = 256
) (
  input logic         clk_i,
  input logic         rst_ni,
  flsa_req_if.sink    req_i,
  flsa_rsp_if.source  rsp_o,
  flsa_cfg_if.sink    cfg_i
);
  import flsa_pkg::*;

  ctrl_cmd_t  cmd;
  dpath_sts_t sts;

  // Configuration writes are always taken. The user must issue them only while the
  // block is idle so that no register changes mid-operation; the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  // The controller sequences one operation at a time: allocate, free and no-op
  // pass through the execute state; a rebuild runs the divider, caps the slot count,
  // sweeps the link RAM and then reports. The result register in the datapath
  // separates the two sides, so a new request transfer is possible while the
  // previous result still waits.
  flsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the head pointer, the counters, the
  // link RAM, the slot-count divider and the result register.
  flsa_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .req_func_i        (req_i.func),
    .req_free_slot_i   (req_i.free_slot),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rsp_status_o      (rsp_o.status),
    .rsp_slot_o        (rsp_o.slot),
    .rsp_address_o     (rsp_o.address),
    .rsp_used_bytes_o  (rsp_o.used_bytes),
    .rsp_allocations_o (rsp_o.allocations)
  );

endmodule

/* rtl/core/flsa_ram.sv */
module flsa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/flsa_ctrl.sv */
module flsa_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic [flsa_pkg::FUNC_W-1:0] req_func_i,
  output logic                        req_ready_o,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  input  flsa_pkg::dpath_sts_t        sts_i,
  output flsa_pkg::ctrl_cmd_t         cmd_o
);
  import flsa_pkg::*;

  state_e    state_q, state_d;
  logic      rsp_valid_q, rsp_valid_d;
  logic      out_free;
  ctrl_cmd_t cmd;

  // The result register can take a new value when empty or drained this cycle.
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = (func_e'(req_func_i) == FUNC_REBUILD) ? ST_DIV : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_CAP;
        end
      end
      ST_CAP: begin
        cmd.cap = 1'b1;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = ST_FIN;
        end else begin
          cmd.sweep_wr = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.rebuild_fin = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd.exec || cmd.rebuild_fin) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign cmd_o       = cmd;

endmodule

/* rtl/core/flsa_dpath.sv */
module flsa_dpath #(
  parameter int SLOTS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [flsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [flsa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [flsa_pkg::FUNC_W-1:0]     req_func_i,
  input  logic [flsa_pkg::SLOT_W-1:0]     req_free_slot_i,
  input  flsa_pkg::ctrl_cmd_t             cmd_i,
  output flsa_pkg::dpath_sts_t            sts_o,
  output logic [flsa_pkg::STATUS_W-1:0]   rsp_status_o,
  output logic [flsa_pkg::SLOT_W-1:0]     rsp_slot_o,
  output logic [flsa_pkg::ADDR_W-1:0]     rsp_address_o,
  output logic [flsa_pkg::USED_W-1:0]     rsp_used_bytes_o,
  output logic [flsa_pkg::ALLOC_W-1:0]    rsp_allocations_o
);
  import flsa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int CW = (LW > SLOT_W) ? LW : SLOT_W;
  localparam int PW = IW + OBJ_W;
  localparam logic [LW-1:0] NullLink = LW'(SLOTS);

  // Configuration.
  logic [ADDR_W-1:0]  base_q;
  logic [POOL_W-1:0]  pool_q;
  logic [OBJ_W-1:0]   obj_q;
  logic [OBJ_W-1:0]   obj_size;

  // List and counters.
  logic [LW-1:0]      head_q, head_d;
  logic [LW-1:0]      slot_total_q, slot_total_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [ALLOC_W-1:0] count_q, count_d;

  // Latched request, address product, divider and sweep.
  func_e              func_q;
  logic [SLOT_W-1:0]  fslot_q;
  logic [PW-1:0]      prod_q;
  logic [OBJ_W-1:0]   rem_q;
  logic [POOL_W-1:0]  quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [LW-1:0]      n_q;
  logic [LW-1:0]      idx_q;
  logic [OBJ_W:0]     div_shift;
  logic               div_ge;
  logic [LW-1:0]      idx_nxt;
  logic [LW-1:0]      sweep_link;

  // Link store port.
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [LW-1:0]      ram_wdata;
  logic [LW-1:0]      ram_rdata;

  // Result register.
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [USED_W-1:0]   out_used_q;
  logic [ALLOC_W-1:0]  out_count_q;
  status_e             status_d;
  logic [SLOT_W-1:0]   slot_d;
  logic [ADDR_W-1:0]   addr_d;

  logic alloc_ok;
  logic free_ok;

  assign obj_size = (obj_q == '0) ? OBJ_W'(1) : obj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      pool_q       <= '0;
      obj_q        <= OBJ_W'(1);
      head_q       <= NullLink;
      slot_total_q <= '0;
      used_q       <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_BASE_ADDRESS: base_q <= cfg_data_i;
          CFG_POOL_BYTES:   pool_q <= cfg_data_i;
          CFG_OBJECT_BYTES: obj_q  <= cfg_data_i[OBJ_W-1:0];
          default: ;
        endcase
      end
      head_q       <= head_d;
      slot_total_q <= slot_total_d;
      used_q       <= used_d;
      count_q      <= count_d;
    end
  end

  // Restoring divider step: one quotient bit per cycle.
  assign div_shift = {rem_q, quo_q[POOL_W-1]};
  assign div_ge    = (div_shift >= {1'b0, obj_size});

  always_ff @(posedge clk_i) begin
    prod_q <= head_q[IW-1:0] * obj_size;
    if (cmd_i.latch) begin
      func_q    <= func_e'(req_func_i);
      fslot_q   <= req_free_slot_i;
      rem_q     <= '0;
      quo_q     <= pool_q;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= div_ge ? OBJ_W'(div_shift - {1'b0, obj_size}) : div_shift[OBJ_W-1:0];
      quo_q     <= {quo_q[POOL_W-2:0], div_ge};
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
    if (cmd_i.cap) begin
      n_q   <= (quo_q > POOL_W'(SLOTS)) ? NullLink : LW'(quo_q);
      idx_q <= '0;
    end
    if (cmd_i.sweep_wr) begin
      idx_q <= idx_nxt;
    end
    if (cmd_i.exec || cmd_i.rebuild_fin) begin
      out_status_q <= status_d;
      out_slot_q   <= slot_d;
      out_addr_q   <= addr_d;
      out_used_q   <= used_d;
      out_count_q  <= count_d;
    end
  end

  assign sts_o.div_last   = (div_cnt_q == '1);
  assign sts_o.sweep_done = (idx_q == n_q);

  assign idx_nxt    = idx_q + LW'(1);
  assign sweep_link = (idx_nxt < n_q) ? idx_nxt : NullLink;

  assign alloc_ok = (head_q < NullLink);
  assign free_ok  = (count_q != '0) && (CW'(fslot_q) < CW'(slot_total_q));

  always_comb begin
    head_d       = head_q;
    slot_total_d = slot_total_q;
    used_d       = used_q;
    count_d      = count_q;
    status_d     = STATUS_OK;
    slot_d       = '0;
    addr_d       = '0;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[IW-1:0];
    ram_wdata    = sweep_link;
    if (cmd_i.exec) begin
      case (func_q)
        FUNC_ALLOC: begin
          if (alloc_ok) begin
            slot_d  = SLOT_W'(head_q);
            addr_d  = base_q + ADDR_W'(prod_q);
            head_d  = ram_rdata;
            used_d  = used_q + USED_W'(obj_size);
            count_d = count_q + ALLOC_W'(1);
          end else begin
            status_d = STATUS_EMPTY;
          end
        end
        FUNC_FREE: begin
          if (free_ok) begin
            ram_we    = 1'b1;
            ram_waddr = IW'(fslot_q);
            ram_wdata = head_q;
            head_d    = LW'(fslot_q);
            used_d    = used_q - USED_W'(obj_size);
            count_d   = count_q - ALLOC_W'(1);
          end else begin
            status_d = STATUS_REJECT;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.sweep_wr) begin
      ram_we = 1'b1;
    end else if (cmd_i.rebuild_fin) begin
      head_d       = (n_q != '0) ? '0 : NullLink;
      slot_total_d = n_q;
      used_d       = '0;
      count_d      = '0;
    end
  end

  flsa_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rsp_status_o      = out_status_q;
  assign rsp_slot_o        = out_slot_q;
  assign rsp_address_o     = out_addr_q;
  assign rsp_used_bytes_o  = out_used_q;
  assign rsp_allocations_o = out_count_q;

endmodule

/* rtl/core/flsa_chk.sv */
module flsa_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [flsa_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [flsa_pkg::SLOT_W-1:0]   rsp_slot_i,
  input logic [flsa_pkg::ADDR_W-1:0]   rsp_address_i,
  input logic [flsa_pkg::USED_W-1:0]   rsp_used_bytes_i,
  input logic [flsa_pkg::ALLOC_W-1:0]  rsp_allocations_i
);
  import flsa_pkg::*;

  // A stalled result holds its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_slot_i) && $stable(rsp_address_i) &&
      $stable(rsp_used_bytes_i) && $stable(rsp_allocations_i))
    else $error("result changed while stalled");

  // Only one operation is in flight: a request transfer blocks the next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while an operation is in flight");

  // A new result only appears after a busy cycle.
  a_rsp_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("result appeared without an operation in progress");

  // Failed operations hand out no slot and no address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STATUS_OK) |-> (rsp_slot_i == '0) &&
      (rsp_address_i == '0))
    else $error("failed operation carries a slot or address");

endmodule

bind free_list_slot_allocator flsa_chk u_flsa_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_slot_i        (rsp_o.slot),
  .rsp_address_i     (rsp_o.address),
  .rsp_used_bytes_i  (rsp_o.used_bytes),
  .rsp_allocations_i (rsp_o.allocations)
);
